// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// next-cycle implication, checked out of reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

`endif

// File: rtl/xxtea_pkg.sv
`default_nettype none

package xxtea_pkg;

  localparam int unsigned MAX_WORDS_DEF = 64;
  localparam int unsigned N_W           = 7;
  localparam int unsigned RND_W         = 6;
  localparam int unsigned UPC_W         = 5;
  localparam int unsigned CFG_IDX_W     = 3;

  localparam logic [31:0] SUM_STEP = 32'h9e37_79b9;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd4;

  // microprogram addresses
  localparam logic [UPC_W-1:0] U_LOAD    = 5'd0;
  localparam logic [UPC_W-1:0] U_START   = 5'd1;
  localparam logic [UPC_W-1:0] U_MODE    = 5'd2;
  localparam logic [UPC_W-1:0] U_E_INIT  = 5'd3;
  localparam logic [UPC_W-1:0] U_E_CAPZ  = 5'd4;
  localparam logic [UPC_W-1:0] U_E_ROUND = 5'd5;
  localparam logic [UPC_W-1:0] U_E_UPD0  = 5'd6;
  localparam logic [UPC_W-1:0] U_E_UPD1  = 5'd7;
  localparam logic [UPC_W-1:0] U_E_UPD2  = 5'd8;
  localparam logic [UPC_W-1:0] U_E_REND  = 5'd9;
  localparam logic [UPC_W-1:0] U_E_DONE  = 5'd10;
  localparam logic [UPC_W-1:0] U_D_INIT  = 5'd11;
  localparam logic [UPC_W-1:0] U_D_CAPY  = 5'd12;
  localparam logic [UPC_W-1:0] U_D_UPD0  = 5'd13;
  localparam logic [UPC_W-1:0] U_D_UPD1  = 5'd14;
  localparam logic [UPC_W-1:0] U_D_UPD2  = 5'd15;
  localparam logic [UPC_W-1:0] U_D_REND  = 5'd16;
  localparam logic [UPC_W-1:0] U_EMIT    = 5'd17;
  localparam logic [UPC_W-1:0] U_EM_RD   = 5'd18;
  localparam logic [UPC_W-1:0] U_EM_OUT  = 5'd19;
  localparam logic [UPC_W-1:0] U_FIN     = 5'd20;

  typedef enum logic [3:0] {
    C_NEXT,
    C_GOTO,
    C_NOT_LAST_IN,
    C_SHORT,
    C_DEC,
    C_P_NOT_LAST,
    C_P_NOT_ZERO,
    C_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef enum logic [2:0] {S_KEEP, S_CLEAR, S_ADD, S_SUB, S_MUL} sum_op_e;
  typedef enum logic [1:0] {R_KEEP, R_LOAD, R_DEC} rnd_op_e;
  typedef enum logic [2:0] {P_KEEP, P_ZERO, P_LAST, P_INC_WRAP, P_DEC_WRAP} p_op_e;
  typedef enum logic [2:0] {RD_P, RD_LAST, RD_FIRST, RD_ENC, RD_DEC} rd_op_e;
  typedef enum logic [1:0] {CAP_NONE, CAP_Z, CAP_Y} cap_e;
  typedef enum logic [1:0] {WR_NONE, WR_ADD, WR_SUB} wr_op_e;

  typedef struct packed {
    cond_e            cond;
    logic [UPC_W-1:0] jmp;
    sum_op_e          sum_op;
    rnd_op_e          rnd_op;
    p_op_e            p_op;
    rd_op_e           rd_op;
    cap_e             cap;
    wr_op_e           wr_op;
    logic             mix_en;
    logic             mix_dec;
    logic             accept_in;
    logic             out_load;
    logic             msg_clr;
  } uword_t;

  // 6 + 52 / n for message lengths of 2 to 127 words
  function automatic logic [RND_W-1:0] rounds_for(logic [N_W-1:0] n);
    logic [RND_W-1:0] r;
    case (n) inside
      7'd2:        r = 6'd32;
      7'd3:        r = 6'd23;
      7'd4:        r = 6'd19;
      7'd5:        r = 6'd16;
      7'd6:        r = 6'd14;
      7'd7:        r = 6'd13;
      7'd8:        r = 6'd12;
      [7'd9:7'd10]:  r = 6'd11;
      [7'd11:7'd13]: r = 6'd10;
      [7'd14:7'd17]: r = 6'd9;
      [7'd18:7'd26]: r = 6'd8;
      [7'd27:7'd52]: r = 6'd7;
      default:     r = 6'd6;
    endcase
    return r;
  endfunction

  // control store
  function automatic uword_t ucode(logic [UPC_W-1:0] addr);
    uword_t w;
    w = '0;
    case (addr)
      U_LOAD: begin
        w.accept_in = 1'b1;
        w.cond      = C_NOT_LAST_IN;
        w.jmp       = U_LOAD;
      end
      U_START: begin
        w.rnd_op = R_LOAD;
        w.cond   = C_SHORT;
        w.jmp    = U_EMIT;
      end
      U_MODE: begin
        w.cond = C_DEC;
        w.jmp  = U_D_INIT;
      end
      U_E_INIT: begin
        w.sum_op = S_CLEAR;
        w.rd_op  = RD_LAST;
        w.p_op   = P_ZERO;
      end
      U_E_CAPZ: begin
        w.cap = CAP_Z;
      end
      U_E_ROUND: begin
        w.sum_op = S_ADD;
      end
      U_E_UPD0: begin
        w.rd_op = RD_ENC;
      end
      U_E_UPD1: begin
        w.rd_op  = RD_ENC;
        w.mix_en = 1'b1;
      end
      U_E_UPD2: begin
        w.wr_op = WR_ADD;
        w.cap   = CAP_Z;
        w.p_op  = P_INC_WRAP;
        w.cond  = C_P_NOT_LAST;
        w.jmp   = U_E_UPD0;
      end
      U_E_REND: begin
        w.rnd_op = R_DEC;
        w.cond   = C_MORE;
        w.jmp    = U_E_ROUND;
      end
      U_E_DONE: begin
        w.cond = C_GOTO;
        w.jmp  = U_EMIT;
      end
      U_D_INIT: begin
        w.sum_op = S_MUL;
        w.rd_op  = RD_FIRST;
        w.p_op   = P_LAST;
      end
      U_D_CAPY: begin
        w.cap = CAP_Y;
      end
      U_D_UPD0: begin
        w.rd_op = RD_DEC;
      end
      U_D_UPD1: begin
        w.rd_op   = RD_DEC;
        w.mix_en  = 1'b1;
        w.mix_dec = 1'b1;
      end
      U_D_UPD2: begin
        w.wr_op = WR_SUB;
        w.cap   = CAP_Y;
        w.p_op  = P_DEC_WRAP;
        w.cond  = C_P_NOT_ZERO;
        w.jmp   = U_D_UPD0;
      end
      U_D_REND: begin
        w.sum_op = S_SUB;
        w.rnd_op = R_DEC;
        w.cond   = C_MORE;
        w.jmp    = U_D_UPD0;
      end
      U_EMIT: begin
        w.p_op = P_ZERO;
      end
      U_EM_RD: begin
        w.rd_op = RD_P;
        w.cond  = C_OUT_BUSY;
        w.jmp   = U_EM_RD;
      end
      U_EM_OUT: begin
        w.out_load = 1'b1;
        w.p_op     = P_INC_WRAP;
        w.cond     = C_P_NOT_LAST;
        w.jmp      = U_EM_RD;
      end
      U_FIN: begin
        w.msg_clr = 1'b1;
        w.cond    = C_GOTO;
        w.jmp     = U_LOAD;
      end
      default: begin
        w.cond = C_GOTO;
        w.jmp  = U_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/xxtea_block_cipher.sv
// XXTEA block cipher engine, encrypt or decrypt of messages of 32-bit words.
// Input channel: data_word_i / last_word_i with in_valid_i, in_stall_o. One word
// is taken per cycle while loading; the word with last_word_i set ends the message.
// Output channel: out_word_o / out_last_o / overflow_o with out_valid_o,
// out_stall_i. Words leave in order, out_last_o on the final one.
// Config channel: cfg_valid_i / cfg_ready_o (always ready), cfg_index_i selects
// key word 0..3 or the decrypt mode bit; write only while the engine is idle.
// A microcoded sequencer drives one message store with two read ports.
// Each word update reads, mixes, then adds and writes back. For n >= 2 words the cipher
// runs R = 6 + 52/n rounds after the last word; then emission starts, each word is read
// and loaded into the output register in turn, and the message is closed.
// A one-word message skips the rounds. Input is stalled from the last word of a message
// until its last result is loaded into the output register and the message is closed.
// Words past MAX_WORDS are dropped and overflow_o is set on every result word.
// A stalled receiver holds the output register; emission waits on it.
// Reset clears keys, mode, counters and the sequencer; the word store is not cleared.
`default_nettype none

`include "assert_macros.svh"

module xxtea_block_cipher #(
  parameter int unsigned MAX_WORDS = xxtea_pkg::MAX_WORDS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [xxtea_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                     cfg_data_i,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic [31:0]                     data_word_i,
  input  wire logic                            last_word_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic [31:0]                     out_word_o,
  output      logic                            out_last_o,
  output      logic                            overflow_o
);
  import xxtea_pkg::*;

  localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_WORDS + 1);

  logic [31:0] store_q [MAX_WORDS];

  logic [UPC_W-1:0] upc_q, upc_d;
  logic [CW-1:0]    count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [AW-1:0]    p_q, p_d;
  logic [31:0]      sum_q, sum_d;
  logic [RND_W-1:0] rnd_q, rnd_d;
  logic [31:0]      z_q, z_d;
  logic [31:0]      y_q, y_d;
  logic [31:0]      mix_q, mix_d;
  logic [31:0]      rd_a_q, rd_b_q;
  logic [31:0]      key_q [4];
  logic             dec_q;
  logic             out_valid_q;
  logic [31:0]      out_word_q;
  logic             out_last_q;
  logic             out_ovf_q;

  uword_t        ctl;
  logic          in_fire, out_fire, cond_true;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] last_idx, rd_addr_a, rd_addr_b, wr_addr;
  logic          p_is_last, p_is_zero, has_room, wr_en;
  logic [31:0]   wr_data, new_word, mix_y, mix_z, mix_a, mix_b;
  logic [1:0]    key_sel;

  assign ctl       = ucode(upc_q);
  assign in_fire   = in_valid_i & ctl.accept_in;
  assign out_fire  = out_valid_q & ~out_stall_i;
  assign cnt_m1    = count_q - CW'(1);
  assign last_idx  = cnt_m1[AW-1:0];
  assign p_is_last = (p_q == last_idx);
  assign p_is_zero = (p_q == '0);
  assign has_room  = (count_q < CW'(MAX_WORDS));

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = ~ctl.accept_in;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_last_o  = out_last_q;
  assign overflow_o  = out_ovf_q;

  // sequencer
  always_comb begin
    case (ctl.cond)
      C_NEXT:        cond_true = 1'b0;
      C_GOTO:        cond_true = 1'b1;
      C_NOT_LAST_IN: cond_true = ~(in_fire & last_word_i);
      C_SHORT:       cond_true = (count_q < CW'(2));
      C_DEC:         cond_true = dec_q;
      C_P_NOT_LAST:  cond_true = ~p_is_last;
      C_P_NOT_ZERO:  cond_true = ~p_is_zero;
      C_MORE:        cond_true = (rnd_q != RND_W'(1));
      C_OUT_BUSY:    cond_true = out_valid_q & out_stall_i;
      default:       cond_true = 1'b0;
    endcase
    upc_d = cond_true ? ctl.jmp : upc_q + UPC_W'(1);
  end

  // store addressing
  always_comb begin
    case (ctl.rd_op)
      RD_LAST:  rd_addr_a = last_idx;
      RD_FIRST: rd_addr_a = '0;
      default:  rd_addr_a = p_q;
    endcase
    case (ctl.rd_op)
      RD_ENC:  rd_addr_b = p_is_last ? '0 : p_q + AW'(1);
      RD_DEC:  rd_addr_b = p_is_zero ? last_idx : p_q - AW'(1);
      default: rd_addr_b = p_q;
    endcase
  end

  // mixing function
  always_comb begin
    mix_y   = ctl.mix_dec ? y_q : rd_b_q;
    mix_z   = ctl.mix_dec ? rd_b_q : z_q;
    key_sel = 2'(p_q) ^ sum_q[3:2];
    mix_a   = ((mix_z >> 5) ^ (mix_y << 2)) + ((mix_y >> 3) ^ (mix_z << 4));
    mix_b   = (sum_q ^ mix_y) + (key_q[key_sel] ^ mix_z);
    mix_d   = ctl.mix_en ? (mix_a ^ mix_b) : mix_q;
  end

  assign new_word = (ctl.wr_op == WR_SUB) ? rd_a_q - mix_q : rd_a_q + mix_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_q;
    wr_data = new_word;
    if (in_fire && has_room) begin
      wr_en   = 1'b1;
      wr_addr = count_q[AW-1:0];
      wr_data = data_word_i;
    end else if (ctl.wr_op != WR_NONE) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
    rd_a_q <= store_q[rd_addr_a];
    rd_b_q <= store_q[rd_addr_b];
  end

  // datapath next values
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (ctl.msg_clr) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (in_fire) begin
      if (has_room) begin
        count_d = count_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end

    case (ctl.p_op)
      P_ZERO:     p_d = '0;
      P_LAST:     p_d = last_idx;
      P_INC_WRAP: p_d = p_is_last ? '0 : p_q + AW'(1);
      P_DEC_WRAP: p_d = p_is_zero ? last_idx : p_q - AW'(1);
      default:    p_d = p_q;
    endcase

    case (ctl.sum_op)
      S_CLEAR: sum_d = '0;
      S_ADD:   sum_d = sum_q + SUM_STEP;
      S_SUB:   sum_d = sum_q - SUM_STEP;
      S_MUL:   sum_d = 32'(32'(rnd_q) * SUM_STEP);
      default: sum_d = sum_q;
    endcase

    case (ctl.rnd_op)
      R_LOAD:  rnd_d = rounds_for(N_W'(count_q));
      R_DEC:   rnd_d = rnd_q - RND_W'(1);
      default: rnd_d = rnd_q;
    endcase

    z_d = z_q;
    y_d = y_q;
    case (ctl.cap)
      CAP_Z:   z_d = (ctl.wr_op != WR_NONE) ? new_word : rd_a_q;
      CAP_Y:   y_d = (ctl.wr_op != WR_NONE) ? new_word : rd_a_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q   <= U_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
      p_q     <= '0;
      sum_q   <= '0;
      rnd_q   <= '0;
    end else begin
      upc_q   <= upc_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      p_q     <= p_d;
      sum_q   <= sum_d;
      rnd_q   <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q   <= z_d;
    y_q   <= y_d;
    mix_q <= mix_d;
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= '0;
      key_q[1] <= '0;
      key_q[2] <= '0;
      key_q[3] <= '0;
      dec_q    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_KEY0: key_q[0] <= cfg_data_i;
        REG_KEY1: key_q[1] <= cfg_data_i;
        REG_KEY2: key_q[2] <= cfg_data_i;
        REG_KEY3: key_q[3] <= cfg_data_i;
        REG_MODE: dec_q    <= cfg_data_i[0];
        default:  ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      out_word_q <= rd_a_q;
      out_last_q <= p_is_last;
      out_ovf_q  <= ovf_q;
    end
  end

  `ASSERT_IMP(a_out_load_free, clk_i, rst_ni, ctl.out_load, !out_valid_q)
  `ASSERT_NXT(a_last_starts_run, clk_i, rst_ni, in_fire && last_word_i, upc_q == U_START)
  `ASSERT_IMP(a_update_has_rounds, clk_i, rst_ni, (upc_q == U_E_UPD2) || (upc_q == U_D_UPD2), rnd_q != '0)
  `ASSERT_IMP(a_start_nonempty, clk_i, rst_ni, upc_q == U_START, count_q != '0)

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  import xxtea_pkg::*;

  localparam int          CAP          = MAX_WORDS_DEF;
  localparam logic [31:0] GOLDEN       = 32'h9e37_79b9;
  localparam int          RAND_WORDS   = 230;
  localparam int          IDLE_SETTLE  = 8;
  localparam int          END_SETTLE   = 40;
  localparam int          MAX_PRINTS   = 60;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        ovf;
  } cipher_word_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_REG, ROW_FLOOD} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  sel;
    logic [31:0]           val;
    logic                  last;
    logic                  typed;
    logic [31:0]           want;
  } stim_row_t;

  localparam int DIR_ROWS = 30;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]          cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [31:0]          data_word_i;
  logic                 last_word_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [31:0]          out_word_o;
  logic                 out_last_o;
  logic                 overflow_o;

  xxtea_block_cipher #(
    .MAX_WORDS(CAP)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_word_i (data_word_i),
    .last_word_i (last_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .out_last_o  (out_last_o),
    .overflow_o  (overflow_o)
  );

  // cipher state kept by the testbench
  logic [31:0]  key_q [4];
  logic         dec_q;
  logic [31:0]  msg_words [CAP];
  int           msg_len;
  logic         msg_dropped;
  cipher_word_t ciph_out [CAP];
  int           ciph_n;

  cipher_word_t cipher_words_due [$];
  cipher_word_t got_item;
  cipher_word_t due_item;

  int errors      = 0;
  int words_in    = 0;
  int words_out   = 0;
  int msgs        = 0;
  int reg_writes  = 0;
  int burst_left  = 0;
  int rand_words  = 0;
  int seg_kind    = 0;
  int seg_left    = 0;

  stim_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_WORD,  '0,               32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{ROW_WORD,  '0,               32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff},
    '{ROW_WORD,  '0,               32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD,  '0,               32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{ROW_WORD,  '0,               32'hffff_ffff, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD,  '0,               32'hffff_ffff, 1'b1, 1'b0, 32'h0},
    '{ROW_WORD,  '0,               32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD,  '0,               32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD,  '0,               32'ha5a5_a5a5, 1'b1, 1'b0, 32'h0},
    '{ROW_REG,   REG_KEY0,         32'hffff_ffff, 1'b0, 1'b0, 32'h0},
    '{ROW_REG,   REG_KEY1,         32'hffff_ffff, 1'b0, 1'b0, 32'h0},
    '{ROW_REG,   REG_KEY2,         32'hffff_ffff, 1'b0, 1'b0, 32'h0},
    '{ROW_REG,   REG_KEY3,         32'hffff_ffff, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD,  '0,               32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD,  '0,               32'h8000_0000, 1'b1, 1'b0, 32'h0},
    '{ROW_REG,   REG_MODE,         32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD,  '0,               32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD,  '0,               32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{ROW_WORD,  '0,               32'hffff_ffff, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD,  '0,               32'h1234_5678, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD,  '0,               32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD,  '0,               32'h8000_0000, 1'b1, 1'b0, 32'h0},
    '{ROW_WORD,  '0,               32'hdead_beef, 1'b1, 1'b1, 32'hdead_beef},
    '{ROW_REG,   REG_UNUSED_LAST,  32'hffff_ffff, 1'b0, 1'b0, 32'h0},
    '{ROW_REG,   REG_KEY1,         32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_FLOOD, '0,               32'(CAP + 1),  1'b1, 1'b0, 32'h0},
    '{ROW_WORD,  '0,               32'h5a5a_5a5a, 1'b1, 1'b1, 32'h5a5a_5a5a},
    '{ROW_REG,   REG_MODE,         32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD,  '0,               32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD,  '0,               32'h0000_0000, 1'b1, 1'b0, 32'h0}
  };

  function automatic logic [31:0] tea_mix(logic [31:0] y, logic [31:0] z, logic [31:0] sum,
                                          int p, logic [1:0] e);
    logic [31:0] a;
    logic [31:0] b;
    a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    b = (sum ^ y) + (key_q[2'(p) ^ e] ^ z);
    return a ^ b;
  endfunction

  function automatic void encipher(int n);
    int          lst;
    int          rnds;
    int          p;
    logic [31:0] sum;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  e;
    lst  = n - 1;
    rnds = 6 + 52 / n;
    sum  = '0;
    z    = msg_words[lst];
    repeat (rnds) begin
      sum = sum + GOLDEN;
      e   = sum[3:2];
      for (p = 0; p < lst; p++) begin
        y = msg_words[p + 1];
        msg_words[p] = msg_words[p] + tea_mix(y, z, sum, p, e);
        z = msg_words[p];
      end
      y = msg_words[0];
      msg_words[lst] = msg_words[lst] + tea_mix(y, z, sum, lst, e);
      z = msg_words[lst];
    end
  endfunction

  function automatic void decipher(int n);
    int          lst;
    int          rnds;
    int          p;
    logic [31:0] sum;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  e;
    lst  = n - 1;
    rnds = 6 + 52 / n;
    sum  = 32'(rnds) * GOLDEN;
    y    = msg_words[0];
    repeat (rnds) begin
      e = sum[3:2];
      for (p = lst; p > 0; p--) begin
        z = msg_words[p - 1];
        msg_words[p] = msg_words[p] - tea_mix(y, z, sum, p, e);
        y = msg_words[p];
      end
      z = msg_words[lst];
      msg_words[0] = msg_words[0] - tea_mix(y, z, sum, 0, e);
      y = msg_words[0];
      sum = sum - GOLDEN;
    end
  endfunction

  // takes one accepted word, leaves the words of a finished message in ciph_out
  function automatic void absorb_word(logic [31:0] w, logic l);
    int n;
    int i;
    ciph_n = 0;
    if (msg_len < CAP) begin
      msg_words[msg_len] = w;
      msg_len++;
    end else begin
      msg_dropped = 1'b1;
    end
    if (!l) return;
    n = msg_len;
    if (n >= 2) begin
      if (dec_q) decipher(n);
      else encipher(n);
    end
    for (i = 0; i < n; i++) ciph_out[i] = '{msg_words[i], i == n - 1, msg_dropped};
    ciph_n      = n;
    msg_len     = 0;
    msg_dropped = 1'b0;
  endfunction

  function automatic void set_reg(logic [CFG_IDX_W-1:0] sel, logic [31:0] val);
    case (sel)
      REG_KEY0: key_q[0] = val;
      REG_KEY1: key_q[1] = val;
      REG_KEY2: key_q[2] = val;
      REG_KEY3: key_q[3] = val;
      REG_MODE: dec_q = val[0];
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < MAX_PRINTS)
      $display("%0t mismatch: %s, got %h want %h", $time, what, got, want);
    errors++;
  endtask

  // one input transfer, with bursts and gaps on the sending side
  task automatic send_word(logic [31:0] w, logic l);
    cfg_valid_i <= 1'b0;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i  <= 1'b1;
    data_word_i <= w;
    last_word_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    words_in++;
  endtask

  task automatic feed_word(logic [31:0] w, logic l);
    int i;
    send_word(w, l);
    absorb_word(w, l);
    for (i = 0; i < ciph_n; i++) cipher_words_due.push_back(ciph_out[i]);
    if (l) msgs++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (cipher_words_due.size() != 0) @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    set_reg(sel, val);
    reg_writes++;
  endtask

  task automatic run_message(int n);
    int i;
    for (i = 0; i < n; i++) begin
      feed_word(pick_word(), i == n - 1);
      rand_words++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // receiver stall pattern: free-running, random, or long on/off stretches
  always @(posedge clk_i) begin
    if (seg_left == 0) begin
      seg_kind = $urandom_range(0, 2);
      seg_left = $urandom_range(20, 150);
    end else begin
      seg_left--;
    end
    case (seg_kind)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 2) == 0);
      default: out_stall_i <= seg_left[3];
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_out++;
      got_item = '{out_word_o, out_last_o, overflow_o};
      if (cipher_words_due.size() == 0) begin
        report_mismatch("result transfer with nothing pending", out_word_o, 32'h0);
      end else begin
        due_item = cipher_words_due.pop_front();
        if (got_item.word !== due_item.word)
          report_mismatch("out_word", got_item.word, due_item.word);
        if (got_item.last !== due_item.last)
          report_mismatch("out_last", 32'(got_item.last), 32'(due_item.last));
        if (got_item.ovf !== due_item.ovf)
          report_mismatch("overflow", 32'(got_item.ovf), 32'(due_item.ovf));
      end
    end
  end

  initial begin
    int        r;
    int        i;
    int        n;
    stim_row_t row;

    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_KEY0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    data_word_i = '0;
    last_word_i = 1'b0;
    out_stall_i = 1'b0;
    for (i = 0; i < 4; i++) key_q[i] = '0;
    dec_q       = 1'b0;
    msg_len     = 0;
    msg_dropped = 1'b0;
    ciph_n      = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < DIR_ROWS; r++) begin
      row = dir_tab[r];
      case (row.kind)
        ROW_REG: begin
          if (!cfg_valid_i) wait_idle();
          write_reg(row.sel, row.val);
        end
        ROW_FLOOD: begin
          for (i = 0; i < int'(row.val); i++) feed_word(pick_word(), i == int'(row.val) - 1);
        end
        default: begin
          if (row.typed) begin
            send_word(row.val, row.last);
            absorb_word(row.val, row.last);
            cipher_words_due.push_back('{row.want, 1'b1, 1'b0});
            msgs++;
          end else begin
            feed_word(row.val, row.last);
          end
        end
      endcase
    end

    while (rand_words < RAND_WORDS) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        if ($urandom_range(0, 1)) write_reg(REG_KEY0, pick_word());
        if ($urandom_range(0, 1)) write_reg(REG_KEY1, pick_word());
        if ($urandom_range(0, 1)) write_reg(REG_KEY2, pick_word());
        if ($urandom_range(0, 1)) write_reg(REG_KEY3, pick_word());
        if ($urandom_range(0, 1)) write_reg(REG_MODE, 32'($urandom_range(0, 1)));
        if ($urandom_range(0, 7) == 0)
          write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)), $urandom);
      end
      r = $urandom_range(0, 99);
      if (r < 10)      n = 1;
      else if (r < 80) n = $urandom_range(2, 8);
      else if (r < 92) n = $urandom_range(9, 30);
      else if (r < 97) n = $urandom_range(31, CAP);
      else             n = $urandom_range(CAP + 1, CAP + 4);
      run_message(n);
    end

    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (cipher_words_due.size() != 0) @(posedge clk_i);
    repeat (END_SETTLE) @(posedge clk_i);

    $display("covered %0d messages: %0d words in, %0d words out, %0d register writes",
             msgs, words_in, words_out, reg_writes);
    $display("both directions, lengths 1 to %0d, pass-through and overflow cases, %0d errors",
             CAP + 4, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
